>>> src/sccal_pkg.sv
// Shared constants and codes for the size class chunk allocator.
package sccal_pkg;
   localparam int ADDR_W    = 26;
   localparam int ORDER_W   = 5;
   localparam int STATUS_W  = 2;
   localparam int CNT_W     = 7;
   localparam int WORD_W    = 64;
   localparam int BIT_W     = 6;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;
endpackage

>>> src/sccal_if.sv
// Request and response channel interfaces of the allocator.
interface sccal_req_if;
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic [sccal_pkg::ORDER_W-1:0]   size_order;
   logic [sccal_pkg::ADDR_W-1:0]    block_addr;

   modport source (output valid, req_type, size_order, block_addr, input ready);
   modport sink   (input valid, req_type, size_order, block_addr, output ready);
endinterface

interface sccal_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sccal_pkg::ADDR_W-1:0]    result_addr;
   logic [sccal_pkg::STATUS_W-1:0]  status;

   modport source (output valid, result_addr, status, input ready);
   modport sink   (input valid, result_addr, status, output ready);
endinterface

>>> src/sccal_ram.sv
// Simple dual port synchronous RAM, one write and one registered read port.
module sccal_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/size_class_chunk_allocator.sv
// Top level: chunk list walker, slot bitmap search and list maintenance.
//
// Usage: requests arrive on req_ch (valid/ready); req_type 0 allocates a block
// of 2^size_order units, 1 frees the block at block_addr. Every request gives
// exactly one response on rsp_ch with result_addr and status. csr_wr_en and
// csr_wr_data set chunk_count (only chunks with an index below it can be newly assigned);
// write it only while no request is in flight.
// One request is handled at a time. Each bitmap word takes a read of the
// bitmap RAM and then a check, each chunk hop a further read of the
// metadata RAM. A new chunk costs a 64 word clear sweep of the bitmap RAM;
// a free reads the chunk metadata, checks and clears the slot bit, scans
// the chunk's words for emptiness and, if it is empty, unlinks it.
// Reset clears the list heads, the chunk assignment flags and the channel
// state; bitmap words are cleared when a chunk is assigned, so no clearing
// pass is needed. A response waiting on a stalled receiver stays in the
// output register; the next request is taken meanwhile but its response
// waits for the register to empty.
module size_class_chunk_allocator #(
   parameter int NUM_CHUNKS = 64,
   parameter int CHUNK_LOG2 = 20,
   parameter int MIN_ORDER  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   sccal_req_if.sink                         req_ch,
   sccal_rsp_if.source                       rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [sccal_pkg::CNT_W-1:0]       csr_wr_data
);
   localparam int ADDR_W   = sccal_pkg::ADDR_W;
   localparam int WORD_W   = sccal_pkg::WORD_W;
   localparam int BIT_W    = sccal_pkg::BIT_W;
   localparam int CI_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int PTR_W    = $clog2(NUM_CHUNKS + 1);
   localparam int SLOT_W   = CHUNK_LOG2 - MIN_ORDER;
   localparam int WORDS    = (SLOT_W > BIT_W) ? (1 << (SLOT_W - BIT_W)) : 1;
   localparam int WI_W     = (SLOT_W > BIT_W) ? (SLOT_W - BIT_W) : 1;
   localparam int SW_W     = WI_W + BIT_W;
   localparam int NUM_CLS  = SLOT_W + 1;
   localparam int CLS_W    = $clog2(NUM_CLS + 1);
   localparam int K_W      = (NUM_CLS > 1) ? $clog2(NUM_CLS) : 1;
   localparam int META_W   = CLS_W + 2 * PTR_W;
   localparam int BM_DEPTH = NUM_CHUNKS * WORDS;
   localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
   localparam int META_AW  = CI_W;
   localparam int RA_W     = (CHUNK_LOG2 + CI_W > ADDR_W) ? CHUNK_LOG2 + CI_W : ADDR_W;
   localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_CHUNKS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ARD  = 4'd1;
   localparam logic [3:0] S_ACHK = 4'd2;
   localparam logic [3:0] S_ANXT = 4'd3;
   localparam logic [3:0] S_NEWC = 4'd4;
   localparam logic [3:0] S_NLNK = 4'd5;
   localparam logic [3:0] S_CLR  = 4'd6;
   localparam logic [3:0] S_FCLS = 4'd7;
   localparam logic [3:0] S_FBIT = 4'd8;
   localparam logic [3:0] S_FRD  = 4'd9;
   localparam logic [3:0] S_FCHK = 4'd10;
   localparam logic [3:0] S_UP   = 4'd11;
   localparam logic [3:0] S_UPW  = 4'd12;
   localparam logic [3:0] S_UN   = 4'd13;
   localparam logic [3:0] S_UNW  = 4'd14;
   localparam logic [3:0] S_DONE = 4'd15;

   logic [3:0]                       state_ff, state_in;
   logic [sccal_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [NUM_CHUNKS-1:0]            assigned_ff, assigned_in;
   logic [PTR_W-1:0]                 head_ff [NUM_CLS];
   logic [PTR_W-1:0]                 head_in [NUM_CLS];
   logic [K_W-1:0]                   k_ff, k_in;
   logic [sccal_pkg::ORDER_W-1:0]    order_ff, order_in;
   logic [WORD_W-1:0]                mask_ff, mask_in;
   logic [WI_W-1:0]                  nwl_ff, nwl_in;
   logic [CI_W-1:0]                  c_ff, c_in;
   logic [WI_W-1:0]                  w_ff, w_in;
   logic [PTR_W-1:0]                 p_ff, p_in, n_ff, n_in, oh_ff, oh_in;
   logic [SW_W-1:0]                  fs_ff, fs_in;
   logic [ADDR_W-1:0]                res_addr_ff, res_addr_in;
   logic [sccal_pkg::STATUS_W-1:0]   res_st_ff, res_st_in;
   logic                             rsp_v_ff, rsp_v_in;
   logic [ADDR_W-1:0]                rsp_addr_ff, rsp_addr_in;
   logic [sccal_pkg::STATUS_W-1:0]   rsp_st_ff, rsp_st_in;

   logic                bm_we;
   logic [BM_AW-1:0]    bm_waddr, bm_raddr;
   logic [WORD_W-1:0]   bm_wdata, bm_rdata;
   logic                meta_we;
   logic [META_AW-1:0]  meta_waddr, meta_raddr;
   logic [META_W-1:0]   meta_wdata, meta_rdata;

   logic [CLS_W-1:0]    m_cls;
   logic [PTR_W-1:0]    m_nxt, m_prv;
   logic [WORD_W-1:0]   cand;
   logic                cand_any;
   logic [BIT_W-1:0]    lz;
   logic                free_found;
   logic [CI_W-1:0]     free_idx;
   logic [CLS_W-1:0]    cls_code;
   logic [ADDR_W-1:0]   cidx_w;
   logic [ADDR_W-1:0]   offs;
   logic [4:0]          e_val;
   logic                ord_ok;
   logic                load_rsp;
   logic [RA_W-1:0]     ra;

   sccal_ram #(.DEPTH(BM_DEPTH), .WIDTH(WORD_W)) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   sccal_ram #(.DEPTH(NUM_CHUNKS), .WIDTH(META_W)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   assign m_cls    = meta_rdata[META_W-1 -: CLS_W];
   assign m_nxt    = meta_rdata[2*PTR_W-1:PTR_W];
   assign m_prv    = meta_rdata[PTR_W-1:0];
   assign cls_code = CLS_W'(k_ff) + CLS_W'(1);
   assign cand     = ~bm_rdata & mask_ff;
   assign cand_any = |cand;

   always_comb begin
      lz = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (cand[i]) begin
            lz = BIT_W'(i);
         end
      end
   end

   always_comb begin
      int lim;
      lim = (int'(cnt_ff) > NUM_CHUNKS) ? NUM_CHUNKS : int'(cnt_ff);
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
         if (!assigned_ff[i] && i < lim) begin
            free_found = 1'b1;
            free_idx   = CI_W'(i);
         end
      end
   end

   assign ord_ok = (req_ch.size_order >= sccal_pkg::ORDER_W'(MIN_ORDER)) &&
                   (req_ch.size_order <= sccal_pkg::ORDER_W'(CHUNK_LOG2));
   assign e_val  = 5'(CHUNK_LOG2) - req_ch.size_order;
   assign cidx_w = req_ch.block_addr >> CHUNK_LOG2;
   assign offs   = req_ch.block_addr & ADDR_W'((64'd1 << CHUNK_LOG2) - 64'd1);
   assign ra     = (RA_W'(c_ff) << CHUNK_LOG2) + (RA_W'({w_ff, lz}) << order_ff);
   assign load_rsp = (state_ff == S_DONE) && (!rsp_v_ff || rsp_ch.ready);

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_v_ff;
   assign rsp_ch.result_addr = rsp_addr_ff;
   assign rsp_ch.status      = rsp_st_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = csr_wr_en ? csr_wr_data : cnt_ff;
      assigned_in = assigned_ff;
      head_in     = head_ff;
      k_in        = k_ff;
      order_in    = order_ff;
      mask_in     = mask_ff;
      nwl_in      = nwl_ff;
      c_in        = c_ff;
      w_in        = w_ff;
      p_in        = p_ff;
      n_in        = n_ff;
      oh_in       = oh_ff;
      fs_in       = fs_ff;
      res_addr_in = res_addr_ff;
      res_st_in   = res_st_ff;
      bm_we       = 1'b0;
      bm_waddr    = BM_AW'(c_ff) * BM_AW'(WORDS) + BM_AW'(w_ff);
      bm_wdata    = '0;
      bm_raddr    = BM_AW'(c_ff) * BM_AW'(WORDS) + BM_AW'(w_ff);
      meta_we     = 1'b0;
      meta_waddr  = c_ff;
      meta_wdata  = '0;
      meta_raddr  = c_ff;
      rsp_v_in    = rsp_v_ff && !rsp_ch.ready;
      rsp_addr_in = rsp_addr_ff;
      rsp_st_in   = rsp_st_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               k_in        = K_W'(req_ch.size_order - sccal_pkg::ORDER_W'(MIN_ORDER));
               order_in    = req_ch.size_order;
               mask_in     = (e_val >= 5'd6) ? '1 :
                             ((WORD_W'(1) << (WORD_W'(1) << e_val)) - WORD_W'(1));
               nwl_in      = (e_val > 5'd6) ?
                             WI_W'((32'd1 << (e_val - 5'd6)) - 32'd1) : '0;
               w_in        = '0;
               res_addr_in = '0;
               if (!ord_ok) begin
                  res_st_in = (req_ch.req_type == sccal_pkg::REQ_FREE) ?
                              sccal_pkg::ST_BAD_FREE : sccal_pkg::ST_NO_SPACE;
                  state_in  = S_DONE;
               end else if (req_ch.req_type == sccal_pkg::REQ_ALLOC) begin
                  if (head_ff[k_in] == NIL) begin
                     state_in = S_NEWC;
                  end else begin
                     c_in     = head_ff[k_in][CI_W-1:0];
                     state_in = S_ARD;
                  end
               end else begin
                  fs_in = SW_W'(offs >> req_ch.size_order);
                  c_in  = cidx_w[CI_W-1:0];
                  if (cidx_w >= ADDR_W'(NUM_CHUNKS) || !assigned_ff[cidx_w[CI_W-1:0]]) begin
                     res_st_in = sccal_pkg::ST_BAD_FREE;
                     state_in  = S_DONE;
                  end else begin
                     meta_raddr = cidx_w[CI_W-1:0];
                     state_in   = S_FCLS;
                  end
               end
            end
         end
         S_ARD: begin
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (cand_any) begin
               bm_we       = 1'b1;
               bm_wdata    = bm_rdata | (WORD_W'(1) << lz);
               res_addr_in = ADDR_W'(ra);
               res_st_in   = sccal_pkg::ST_OK;
               state_in    = S_DONE;
            end else if (w_ff != nwl_ff) begin
               w_in     = w_ff + WI_W'(1);
               state_in = S_ARD;
            end else begin
               state_in = S_ANXT;
            end
         end
         S_ANXT: begin
            w_in = '0;
            if (m_nxt == NIL) begin
               state_in = S_NEWC;
            end else begin
               c_in     = m_nxt[CI_W-1:0];
               state_in = S_ARD;
            end
         end
         S_NEWC: begin
            if (!free_found) begin
               res_st_in = sccal_pkg::ST_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               meta_we              = 1'b1;
               meta_waddr           = free_idx;
               meta_wdata           = {cls_code, head_ff[k_ff], NIL};
               oh_in                = head_ff[k_ff];
               head_in[k_ff]        = PTR_W'(free_idx);
               assigned_in[free_idx] = 1'b1;
               c_in                 = free_idx;
               w_in                 = '0;
               meta_raddr           = head_ff[k_ff][CI_W-1:0];
               state_in             = (head_ff[k_ff] == NIL) ? S_CLR : S_NLNK;
            end
         end
         S_NLNK: begin
            meta_we    = 1'b1;
            meta_waddr = oh_ff[CI_W-1:0];
            meta_wdata = {m_cls, m_nxt, PTR_W'(c_ff)};
            state_in   = S_CLR;
         end
         S_CLR: begin
            bm_we    = 1'b1;
            bm_wdata = (w_ff == '0) ? WORD_W'(1) : '0;
            if (w_ff == WI_W'(WORDS - 1)) begin
               res_addr_in = ADDR_W'(RA_W'(c_ff) << CHUNK_LOG2);
               res_st_in   = sccal_pkg::ST_OK;
               state_in    = S_DONE;
            end else begin
               w_in = w_ff + WI_W'(1);
            end
         end
         S_FCLS: begin
            if (m_cls != cls_code) begin
               res_st_in = sccal_pkg::ST_BAD_FREE;
               state_in  = S_DONE;
            end else begin
               p_in     = m_prv;
               n_in     = m_nxt;
               w_in     = fs_ff[SW_W-1:BIT_W];
               bm_raddr = BM_AW'(c_ff) * BM_AW'(WORDS) + BM_AW'(fs_ff[SW_W-1:BIT_W]);
               state_in = S_FBIT;
            end
         end
         S_FBIT: begin
            if (!bm_rdata[fs_ff[BIT_W-1:0]]) begin
               res_st_in = sccal_pkg::ST_BAD_FREE;
               state_in  = S_DONE;
            end else begin
               bm_we    = 1'b1;
               bm_wdata = bm_rdata & ~(WORD_W'(1) << fs_ff[BIT_W-1:0]);
               w_in     = '0;
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            state_in = S_FCHK;
         end
         S_FCHK: begin
            res_st_in = sccal_pkg::ST_OK;
            if (bm_rdata != '0) begin
               state_in = S_DONE;
            end else if (w_ff != nwl_ff) begin
               w_in     = w_ff + WI_W'(1);
               state_in = S_FRD;
            end else begin
               state_in = S_UP;
            end
         end
         S_UP: begin
            if (p_ff != NIL) begin
               meta_raddr = p_ff[CI_W-1:0];
               state_in   = S_UPW;
            end else begin
               head_in[k_ff] = n_ff;
               state_in      = S_UN;
            end
         end
         S_UPW: begin
            meta_we    = 1'b1;
            meta_waddr = p_ff[CI_W-1:0];
            meta_wdata = {m_cls, n_ff, m_prv};
            state_in   = S_UN;
         end
         S_UN: begin
            if (n_ff != NIL) begin
               meta_raddr = n_ff[CI_W-1:0];
               state_in   = S_UNW;
            end else begin
               assigned_in[c_ff] = 1'b0;
               state_in          = S_DONE;
            end
         end
         S_UNW: begin
            meta_we           = 1'b1;
            meta_waddr        = n_ff[CI_W-1:0];
            meta_wdata        = {m_cls, m_nxt, p_ff};
            assigned_in[c_ff] = 1'b0;
            state_in          = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_v_in    = 1'b1;
               rsp_addr_in = res_addr_ff;
               rsp_st_in   = res_st_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= sccal_pkg::CNT_W'(64);
         assigned_ff <= '0;
         for (int i = 0; i < NUM_CLS; i++) begin
            head_ff[i] <= NIL;
         end
         rsp_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         assigned_ff <= assigned_in;
         head_ff     <= head_in;
         rsp_v_ff    <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      order_ff    <= order_in;
      mask_ff     <= mask_in;
      nwl_ff      <= nwl_in;
      c_ff        <= c_in;
      w_ff        <= w_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      oh_ff       <= oh_in;
      fs_ff       <= fs_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
   end

   a_walk_assigned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ARD) |-> assigned_ff[c_ff])
      else $error("walking an unassigned chunk");

   a_clr_assigned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> assigned_ff[c_ff])
      else $error("clearing bitmap of unassigned chunk");

   a_new_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEWC && free_found) |=> assigned_ff[c_ff])
      else $error("new chunk not marked assigned");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (rsp_st_ff == sccal_pkg::ST_OK || rsp_st_ff == sccal_pkg::ST_NO_SPACE ||
                    rsp_st_ff == sccal_pkg::ST_BAD_FREE))
      else $error("bad status code");

   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_st_ff != sccal_pkg::ST_OK) |-> (rsp_addr_ff == '0))
      else $error("error response with nonzero address");
endmodule
